/* design/tcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and controller/datapath link types for the
// text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // default geometry
  localparam int COLUMNS_DEF    = 80;
  localparam int ROWS_DEF       = 25;
  localparam int TAB_SPACES_DEF = 4;

  // fixed field widths
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int ADDR_W    = 11;
  localparam int CELL_W    = 16;
  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

  // request codes
  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch the accepted item
    logic put;       // one plain character step
    logic clr;       // post-reset clearing step
    logic scr;       // one scroll step
    logic rd;        // issue screen read
    logic cap;       // capture read data
    logic out_load;  // move result into the output register
  } tcw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_is_read;  // request type of the offered item
    logic is_nul;      // held character is NUL, or held item is a read
    logic put_scroll;  // this put step runs off the last row
    logic put_more;    // further steps after this put step
    logic cnt_left;    // steps still outstanding
    logic clr_end;     // last cell of the clearing pass
    logic scr_end;     // last step of the scroll
    logic out_free;    // output register can take a result
  } tcw_status_t;

endpackage

/* design/text_console_writer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text-mode console engine over a ROWS x COLUMNS screen of 16-bit cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item: a put of
//   char_code_i at the cursor, or a read of the cell at cell_address_i.
//   Every item yields exactly one result item on the output channel
//   (out_valid_o / out_stall_i): read cell, cursor after the item and a
//   flag that is set when the item scrolled the screen.
//   The attribute register is written through cfg_valid_i / cfg_data_i;
//   cfg_ready_o is always high. Write it only while the block is idle.
// Sequencing, one item at a time (the next item is accepted only after
//   the last has handed off its result): a plain put, newline or NUL
//   takes one put step; a read goes through a registered RAM read.
//   A put that runs off the last row adds a scroll: the scroll copies the
//   screen up one cell per cycle through the single read and single write
//   port of the screen RAM, then blanks the bottom row.
//   tab: TAB_SPACES put steps, plus any scroll.
// Reset: cursor to the top-left, attribute 0x07, then a clearing pass
//   writes a space in every cell; in_stall_o stays high until it ends.
// Receiver stall: the result sits in the output register; the next item
//   is still accepted and worked on, and waits only to hand off its result.
// ----------------------------------------------------------------------------
module text_console_writer_unit #(
  parameter int COLUMNS    = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS       = tcw_pkg::ROWS_DEF,
  parameter int TAB_SPACES = tcw_pkg::TAB_SPACES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            req_type_i,
  input  logic [tcw_pkg::CHAR_W-1:0]      char_code_i,
  input  logic [tcw_pkg::ADDR_W-1:0]      cell_address_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [tcw_pkg::CELL_W-1:0]      cell_value_o,
  output logic [tcw_pkg::ROW_OUT_W-1:0]   cursor_row_o,
  output logic [tcw_pkg::COL_OUT_W-1:0]   cursor_column_o,
  output logic                            scrolled_o,
  // attribute register write
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tcw_pkg::ATTR_W-1:0]      cfg_data_i
);

  import tcw_pkg::*;

  tcw_cmd_t    cmd;
  tcw_status_t status;

  // register write never waits
  assign cfg_ready_o = 1'b1;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tcw_datapath #(
    .COLUMNS    (COLUMNS),
    .ROWS       (ROWS),
    .TAB_SPACES (TAB_SPACES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .req_type_i      (req_type_i),
    .char_code_i     (char_code_i),
    .cell_address_i  (cell_address_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .cell_value_o    (cell_value_o),
    .cursor_row_o    (cursor_row_o),
    .cursor_column_o (cursor_column_o),
    .scrolled_o      (scrolled_o)
  );

endmodule

/* design/tcw_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* design/tcw_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_datapath
// Cursor, screen memory, scroll/clear scan counter and result registers.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int COLUMNS    = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS       = tcw_pkg::ROWS_DEF,
  parameter int TAB_SPACES = tcw_pkg::TAB_SPACES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tcw_pkg::tcw_cmd_t               cmd_i,
  output tcw_pkg::tcw_status_t            status_o,
  input  logic                            req_type_i,
  input  logic [tcw_pkg::CHAR_W-1:0]      char_code_i,
  input  logic [tcw_pkg::ADDR_W-1:0]      cell_address_i,
  input  logic                            cfg_valid_i,
  input  logic [tcw_pkg::ATTR_W-1:0]      cfg_data_i,
  input  logic                            out_stall_i,
  output logic                            out_valid_o,
  output logic [tcw_pkg::CELL_W-1:0]      cell_value_o,
  output logic [tcw_pkg::ROW_OUT_W-1:0]   cursor_row_o,
  output logic [tcw_pkg::COL_OUT_W-1:0]   cursor_column_o,
  output logic                            scrolled_o
);

  import tcw_pkg::*;

  localparam int CellCount = ROWS * COLUMNS;
  localparam int CopyCount = CellCount - COLUMNS;
  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLUMNS);
  localparam int AW = $clog2(CellCount);
  localparam int SW = $clog2(CellCount + 1);
  localparam int TW = $clog2(TAB_SPACES + 1);

  // item registers
  logic              req_q;
  logic [CHAR_W-1:0] char_q;
  logic [ADDR_W-1:0] addr_q;
  logic [TW-1:0]     cnt_q;
  logic              scrolled_q;
  logic [CELL_W-1:0] value_q;

  // state
  logic [RW-1:0]     row_q;
  logic [CW-1:0]     col_q;
  logic [ATTR_W-1:0] attr_q;
  logic [SW-1:0]     scan_q;

  // output register
  logic              out_valid_q;
  logic [CELL_W-1:0] out_cell_q;
  logic [RW-1:0]     out_row_q;
  logic [CW-1:0]     out_col_q;
  logic              out_scr_q;

  // RAM port
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [CELL_W-1:0] rd_data;

  // put step decode
  logic              is_tab;
  logic              is_nul;
  logic [CHAR_W-1:0] put_ch;
  logic              is_lf;
  logic              wrap;
  logic              last_row;
  logic              put_scroll;
  logic [AW-1:0]     cursor_idx;
  logic              copy_rd;
  logic              copy_wr;
  logic              in_range;

  assign is_tab     = (char_q == CH_TAB);
  assign is_nul     = (char_q == CH_NUL);
  assign put_ch     = is_tab ? CH_SPACE : char_q;
  assign is_lf      = (put_ch == CH_LF);
  assign wrap       = is_lf || (col_q == CW'(COLUMNS - 1));
  assign last_row   = (row_q == RW'(ROWS - 1));
  assign put_scroll = !is_nul && wrap && last_row;
  assign cursor_idx = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
  assign copy_rd    = (scan_q < SW'(CopyCount));
  assign copy_wr    = (scan_q <= SW'(CopyCount));
  assign in_range   = (32'(addr_q) < 32'(CellCount));

  // write port: clearing pass, scroll, then a character put
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cursor_idx;
    wr_data = {attr_q, put_ch};
    if (cmd_i.clr) begin
      wr_en   = 1'b1;
      wr_addr = AW'(scan_q);
      wr_data = {RESET_ATTR, CH_SPACE};
    end else if (cmd_i.scr) begin
      wr_en   = (scan_q != '0);
      wr_addr = AW'(scan_q - SW'(1));
      wr_data = copy_wr ? rd_data : {attr_q, CH_SPACE};
    end else if (cmd_i.put) begin
      wr_en   = !is_nul && !is_lf;
    end
  end

  // read port: scroll source one row below, or a read request
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(addr_q);
    if (cmd_i.scr) begin
      rd_en   = copy_rd;
      rd_addr = AW'(scan_q + SW'(COLUMNS));
    end else if (cmd_i.rd) begin
      rd_en   = in_range;
    end
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CellCount)
  ) u_screen (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // item payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_type_i;
      char_q <= char_code_i;
      addr_q <= cell_address_i;
    end
    if (cmd_i.load) begin
      value_q <= '0;
    end else if (cmd_i.cap) begin
      value_q <= in_range ? rd_data : '0;
    end
    if (cmd_i.out_load) begin
      out_cell_q <= value_q;
      out_row_q  <= row_q;
      out_col_q  <= col_q;
      out_scr_q  <= scrolled_q;
    end
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      attr_q      <= RESET_ATTR;
      scan_q      <= '0;
      cnt_q       <= '0;
      scrolled_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        attr_q <= cfg_data_i;
      end

      if (cmd_i.load) begin
        cnt_q      <= (char_code_i == CH_TAB) ? TW'(TAB_SPACES) : TW'(1);
        scrolled_q <= 1'b0;
      end else if (cmd_i.put) begin
        cnt_q <= cnt_q - TW'(1);
        if (!is_nul) begin
          if (wrap) begin
            col_q <= '0;
            if (!last_row) begin
              row_q <= row_q + RW'(1);
            end
          end else begin
            col_q <= col_q + CW'(1);
          end
        end
        if (put_scroll) begin
          scrolled_q <= 1'b1;
        end
      end

      if (cmd_i.put) begin
        scan_q <= '0;
      end else if (cmd_i.clr || cmd_i.scr) begin
        scan_q <= scan_q + SW'(1);
      end

      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    status_o.in_is_read = (req_type_i == REQ_READ);
    status_o.is_nul     = is_nul || (req_q == REQ_READ);
    status_o.put_scroll = put_scroll;
    status_o.put_more   = (cnt_q > TW'(1));
    status_o.cnt_left   = (cnt_q != '0);
    status_o.clr_end    = (scan_q == SW'(CellCount - 1));
    status_o.scr_end    = (scan_q == SW'(CellCount));
    status_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o     = out_valid_q;
  assign cell_value_o    = out_cell_q;
  assign cursor_row_o    = ROW_OUT_W'(out_row_q);
  assign cursor_column_o = COL_OUT_W'(out_col_q);
  assign scrolled_o      = out_scr_q;

endmodule

/* design/tcw_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: clearing pass, put steps, scroll, reads and result hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tcw_pkg::tcw_status_t status_i,
  output tcw_pkg::tcw_cmd_t    cmd_o
);

  import tcw_pkg::*;

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_PUT     = 3'd2;
  localparam logic [2:0] S_SCROLL  = 3'd3;
  localparam logic [2:0] S_READ    = 3'd4;
  localparam logic [2:0] S_CAPTURE = 3'd5;
  localparam logic [2:0] S_FINISH  = 3'd6;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_end) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.in_is_read ? S_READ : S_PUT;
        end
      end
      S_PUT: begin
        cmd_o.put = 1'b1;
        if (status_i.is_nul) begin
          state_d = S_FINISH;
        end else if (status_i.put_scroll) begin
          state_d = S_SCROLL;
        end else if (!status_i.put_more) begin
          state_d = S_FINISH;
        end
      end
      S_SCROLL: begin
        cmd_o.scr = 1'b1;
        if (status_i.scr_end) begin
          state_d = status_i.cnt_left ? S_PUT : S_FINISH;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CAPTURE;
      end
      S_CAPTURE: begin
        cmd_o.cap = 1'b1;
        state_d   = S_FINISH;
      end
      S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
